/* rtl/core/brct_pkg.sv */
// Package: opcodes and field widths shared by the byte range coverage tracker.
`timescale 1ns / 1ps
package brct_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_LIST  = 2'd2,
    OP_GAPS  = 2'd3
  } op_t;

  localparam int FIELD_W     = 33;
  localparam int OFFSET_BITS = 32;
endpackage

/* rtl/core/brct_table.sv */
// Range table: start/length register file, one write port, one read port.
`timescale 1ns / 1ps
module brct_table #(
  parameter int W     = 33,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wstart,
  input  logic [W-1:0]  wlen,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rstart,
  output logic [W-1:0]  rlen
);
  logic [W-1:0] starts [DEPTH];
  logic [W-1:0] lens   [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      starts[waddr] <= wstart;
      lens[waddr]   <= wlen;
    end
  end

  assign rstart = starts[raddr];
  assign rlen   = lens[raddr];
endmodule

/* rtl/core/byte_range_coverage_tracker.sv */
// Top level: sorted disjoint byte range set with merge-on-add, list and gap walks.
`timescale 1ns / 1ps
// The block holds up to MAX_RANGES sorted, disjoint, non-touching byte ranges
// and takes one item at a time: in_ready is high only while the sequencer is
// idle. An add scans the table one entry a cycle to find the merge window,
// then shifts the tail one entry a cycle through the single table write port,
// writes the merged range and reports when the output is free. A list emits
// one stored range a cycle while the output is free; a gaps walk reads one
// entry a cycle unless a held gap waits for the output, and emits each gap
// one entry late so the final one can carry last. Every result carries the
// covered byte total after the operation. The output register lets one result
// wait for out_ready while the walk holds; file_size is to be written through
// cfg_we/cfg_data only while the block is idle, which the block does not enforce.
module byte_range_coverage_tracker
  import brct_pkg::*;
#(
  parameter int MAX_RANGES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [32:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] range_start,
  input  logic [31:0] range_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] out_start,
  output logic [32:0] out_length,
  output logic        none_listed,
  output logic [32:0] total_covered,
  output logic        overflow,
  output logic        last
);
  localparam int EW   = OFFSET_BITS + 1;
  localparam int CW   = (EW > FIELD_W) ? EW : FIELD_W;
  localparam int CNTW = $clog2(MAX_RANGES + 1);
  localparam int IW   = $clog2(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_SCAN, S_DECIDE, S_SHUP, S_SHDN, S_WRITE,
    S_LIST, S_GAPS, S_TAIL, S_FLUSH
  } state_t;

  state_t            state;
  logic [32:0]       file_size;
  logic [CNTW-1:0]   count, i, j, d, lo, hi, k;
  logic [32:0]       total, msum;
  logic [EW-1:0]     s_r, e_r, ns, ne, cur;
  logic              lo_found, ovf_r, none_r;
  logic              pend_v;
  logic [CW-1:0]     pend_s, pend_l;

  logic [IW-1:0]     rd_idx, wr_idx;
  logic [EW-1:0]     rd_start, rd_len, rd_end, wr_start, wr_len;
  logic              wr_en, can_emit, out_load;
  logic [63:0]       in_s64, in_l64;
  logic [EW-1:0]     in_s, in_l;
  logic [CNTW-1:0]   newcount;
  logic [EW-1:0]     mlen;
  logic [CW-1:0]     fs_c, cur_c, gap_l, mlen_c;

  assign in_s64   = 64'(range_start);
  assign in_l64   = 64'(range_length);
  assign in_s     = {1'b0, in_s64[OFFSET_BITS-1:0]};
  assign in_l     = {1'b0, in_l64[OFFSET_BITS-1:0]};
  assign rd_end   = rd_start + rd_len;
  assign can_emit = !out_valid || out_ready;
  assign newcount = CNTW'(count - k + 1'b1);
  assign mlen     = ne - ns;
  assign mlen_c   = CW'(mlen);
  assign fs_c     = CW'(file_size);
  assign cur_c    = CW'(cur);
  assign gap_l    = CW'(rd_start - cur);
  assign in_ready = (state == S_IDLE);

  // Load the output register in the states that emit a result this cycle.
  always_comb begin
    case (state)
      S_RESP, S_LIST, S_FLUSH: out_load = can_emit;
      S_GAPS:  out_load = (i != count) && (rd_start > cur) && pend_v && can_emit;
      S_TAIL:  out_load = (fs_c > cur_c) && pend_v && can_emit;
      default: out_load = 1'b0;
    endcase
  end

  // Read address follows the walk; write address follows the shift or merge.
  always_comb begin
    rd_idx   = i[IW-1:0];
    wr_idx   = lo[IW-1:0];
    wr_start = ns;
    wr_len   = mlen;
    wr_en    = 1'b0;
    case (state)
      S_SHUP: begin
        rd_idx   = IW'(j - 1'b1);
        wr_idx   = j[IW-1:0];
        wr_start = rd_start;
        wr_len   = rd_len;
        wr_en    = (j != lo);
      end
      S_SHDN: begin
        rd_idx   = j[IW-1:0];
        wr_idx   = d[IW-1:0];
        wr_start = rd_start;
        wr_len   = rd_len;
        wr_en    = (j != count);
      end
      S_WRITE: wr_en = 1'b1;
      default: ;
    endcase
  end

  brct_table #(.W(EW), .DEPTH(MAX_RANGES), .AW(IW)) u_table (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_idx),
    .wstart (wr_start),
    .wlen   (wr_len),
    .raddr  (rd_idx),
    .rstart (rd_start),
    .rlen   (rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      file_size <= '0;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (cfg_we) file_size <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            i      <= '0;
            ovf_r  <= 1'b0;
            none_r <= 1'b0;
            s_r    <= in_s;
            e_r    <= in_s + in_l;
            ns     <= in_s;
            ne     <= in_s + in_l;
            k      <= '0;
            msum   <= '0;
            lo_found <= 1'b0;
            cur    <= '0;
            pend_v <= 1'b0;
            case (op_t'(opcode))
              OP_CLEAR: begin
                count <= '0;
                total <= '0;
                state <= S_RESP;
              end
              OP_ADD:  state <= (in_l == '0) ? S_RESP : S_SCAN;
              OP_LIST: begin
                none_r <= (count == '0);
                state  <= (count == '0) ? S_RESP : S_LIST;
              end
              OP_GAPS: state <= S_GAPS;
              default: state <= S_RESP;
            endcase
          end
        end
        S_RESP: begin
          if (can_emit) begin
            out_start     <= '0;
            out_length    <= '0;
            none_listed   <= none_r;
            total_covered <= total;
            overflow      <= ovf_r;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Skip ranges ending before the new start; absorb those overlapping or touching it.
          if (i == count) begin
            if (!lo_found) lo <= count;
            hi    <= count;
            state <= S_DECIDE;
          end else if (!lo_found && rd_end < s_r) begin
            i <= i + 1'b1;
          end else if (rd_start <= e_r) begin
            if (!lo_found) lo <= i;
            lo_found <= 1'b1;
            k    <= k + 1'b1;
            if (rd_start < ns) ns <= rd_start;
            if (rd_end > ne) ne <= rd_end;
            msum <= msum + rd_len[32:0] + 33'(CW'(rd_len) >> 33);
            i    <= i + 1'b1;
          end else begin
            if (!lo_found) lo <= i;
            hi    <= i;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (32'(newcount) > 32'(MAX_RANGES)) begin
            ovf_r <= 1'b1;
            state <= S_RESP;
          end else if (k == '0) begin
            j     <= count;
            state <= S_SHUP;
          end else begin
            d     <= CNTW'(lo + 1'b1);
            j     <= hi;
            state <= S_SHDN;
          end
        end
        S_SHUP: begin
          if (j == lo) state <= S_WRITE;
          else j <= j - 1'b1;
        end
        S_SHDN: begin
          if (j == count) state <= S_WRITE;
          else begin
            j <= j + 1'b1;
            d <= d + 1'b1;
          end
        end
        S_WRITE: begin
          count <= newcount;
          total <= total - msum + mlen_c[32:0];
          state <= S_RESP;
        end
        S_LIST: begin
          if (can_emit) begin
            out_start     <= CW'(rd_start);
            out_length    <= CW'(rd_len);
            none_listed   <= 1'b0;
            total_covered <= total;
            overflow      <= 1'b0;
            last          <= (i == CNTW'(count - 1'b1));
            i             <= i + 1'b1;
            if (i == CNTW'(count - 1'b1)) state <= S_IDLE;
          end
        end
        S_GAPS: begin
          // Hold each gap one step so the final one can be marked last.
          if (i == count) begin
            state <= S_TAIL;
          end else if (rd_start > cur) begin
            if (!pend_v || can_emit) begin
              if (pend_v) begin
                out_start     <= pend_s[32:0];
                out_length    <= pend_l[32:0];
                none_listed   <= 1'b0;
                total_covered <= total;
                overflow      <= 1'b0;
                last          <= 1'b0;
              end
              pend_v <= 1'b1;
              pend_s <= cur_c;
              pend_l <= gap_l;
              cur    <= rd_end;
              i      <= i + 1'b1;
            end
          end else begin
            cur <= rd_end;
            i   <= i + 1'b1;
          end
        end
        S_TAIL: begin
          if (fs_c > cur_c) begin
            if (!pend_v || can_emit) begin
              if (pend_v) begin
                out_start     <= pend_s[32:0];
                out_length    <= pend_l[32:0];
                none_listed   <= 1'b0;
                total_covered <= total;
                overflow      <= 1'b0;
                last          <= 1'b0;
              end
              pend_v <= 1'b1;
              pend_s <= cur_c;
              pend_l <= fs_c - cur_c;
              state  <= S_FLUSH;
            end
          end else begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (can_emit) begin
            out_start     <= pend_v ? pend_s[32:0] : '0;
            out_length    <= pend_v ? pend_l[32:0] : '0;
            none_listed   <= !pend_v;
            total_covered <= total;
            overflow      <= 1'b0;
            last          <= 1'b1;
            pend_v        <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_RANGES)) else $error("range count above table depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
  a_ovf_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (last && !none_listed && out_length == '0))
    else $error("overflow result malformed");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_listed) |-> (last && out_start == '0 && out_length == '0))
    else $error("empty list result malformed");
endmodule

/* sim/tb.sv */
// Testbench for the byte range coverage tracker: directed and random items, self-checking.
`timescale 1ns / 1ps
module tb;
  import brct_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    op_t         op;
    logic [31:0] start;
    logic [31:0] len;
  } range_item_t;

  typedef struct packed {
    logic [32:0] start;
    logic [32:0] len;
    logic        none;
    logic [32:0] total;
    logic        ovf;
    logic        last;
  } range_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [32:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_CLEAR;
  logic [31:0] range_start = '0;
  logic [31:0] range_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [32:0] out_start, out_length, total_covered;
  logic        none_listed, overflow, last;

  byte_range_coverage_tracker i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .range_start(range_start), .range_length(range_length),
    .out_valid(out_valid), .out_ready(out_ready), .out_start(out_start),
    .out_length(out_length), .none_listed(none_listed),
    .total_covered(total_covered), .overflow(overflow), .last(last)
  );

  always #5 clk = ~clk;

  // Model state: sorted disjoint table, running total, gap bound.
  logic [32:0] span_start [TABLE_DEPTH];
  logic [32:0] span_len [TABLE_DEPTH];
  int          span_count = 0;
  logic [32:0] covered = '0;
  logic [32:0] file_size = '0;

  range_item_t   pending_items[$];
  range_result_t expected_results[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  driver_done = 1'b0;
  bit  hold_off_req = 1'b0;
  int  hold_off_left = 0;
  bit  in_taken = 1'b0;

  function automatic range_result_t make_result(logic [32:0] s, logic [32:0] l,
                                                logic none, logic ovf);
    range_result_t r;
    r.start = s; r.len = l; r.none = none; r.total = covered; r.ovf = ovf;
    r.last = 1'b0;
    return r;
  endfunction

  // Merge a range into the table; return 1 when the table would overflow.
  function automatic logic merge_span(logic [32:0] s, logic [32:0] l);
    logic [32:0] e, ns, ne, le, sum;
    int lo, hi, k, newcount, i;
    e = s + l; ns = s; ne = e; lo = 0;
    if (l == 0) return 1'b0;
    while (lo < span_count && span_start[lo] + span_len[lo] < s) lo++;
    hi = lo;
    while (hi < span_count && span_start[hi] <= e) hi++;
    k = hi - lo;
    newcount = span_count - k + 1;
    if (newcount > TABLE_DEPTH) return 1'b1;
    if (k > 0) begin
      le = span_start[hi-1] + span_len[hi-1];
      if (span_start[lo] < ns) ns = span_start[lo];
      if (le > ne) ne = le;
    end
    // Move the tail next to the merged entry, opening or closing the table.
    if (k == 0) begin
      for (i = span_count - hi - 1; i >= 0; i--) begin
        span_start[lo+1+i] = span_start[hi+i];
        span_len[lo+1+i] = span_len[hi+i];
      end
    end else begin
      for (i = 0; i < span_count - hi; i++) begin
        span_start[lo+1+i] = span_start[hi+i];
        span_len[lo+1+i] = span_len[hi+i];
      end
    end
    span_start[lo] = ns;
    span_len[lo] = ne - ns;
    span_count = newcount;
    sum = '0;
    for (i = 0; i < span_count; i++) sum += span_len[i];
    covered = sum;
    return 1'b0;
  endfunction

  function automatic void predict_coverage(range_item_t it);
    range_result_t rq[$];
    logic [32:0] cur;
    logic ovf;
    cur = '0;
    case (it.op)
      OP_CLEAR: begin
        span_count = 0; covered = '0;
        rq.push_back(make_result('0, '0, 1'b0, 1'b0));
      end
      OP_ADD: begin
        ovf = merge_span({1'b0, it.start}, {1'b0, it.len});
        rq.push_back(make_result('0, '0, 1'b0, ovf));
      end
      OP_LIST: begin
        for (int i = 0; i < span_count; i++)
          rq.push_back(make_result(span_start[i], span_len[i], 1'b0, 1'b0));
      end
      default: begin
        for (int i = 0; i < span_count; i++) begin
          if (span_start[i] > cur)
            rq.push_back(make_result(cur, span_start[i] - cur, 1'b0, 1'b0));
          cur = span_start[i] + span_len[i];
        end
        if (file_size > cur)
          rq.push_back(make_result(cur, file_size - cur, 1'b0, 1'b0));
      end
    endcase
    if (rq.size() == 0) rq.push_back(make_result('0, '0, 1'b1, 1'b0));
    rq[rq.size()-1].last = 1'b1;
    foreach (rq[i]) expected_results.push_back(rq[i]);
  endfunction

  function automatic int gap_len();
    // Mostly short gaps, now and then a long one.
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Input accept: note it at the rising edge and predict its results.
  always @(posedge clk) begin
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) predict_coverage('{op_t'(opcode), range_start, range_length});
  end

  // Driver: offer items from the pending queue with random gaps; change at falling edge.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) idle_cycles <= 0;
      if (!in_valid || in_taken) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
          if (pending_items.size() == 0) driver_done <= 1'b1;
        end else begin
          range_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          opcode <= it.op;
          range_start <= it.start;
          range_length <= it.len;
          send_gap = gap_len();
          driver_done <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_req || hold_off_left > 0) begin
      out_ready <= 1'b0;
      if (hold_off_req && hold_off_left == 0) hold_off_left = 300;
      else hold_off_left--;
    end else begin
      out_ready <= (gap_len() == 0);
    end
  end

  // Monitor: sample at the rising edge and compare with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        range_result_t got, exp;
        got = '{out_start, out_length, none_listed, total_covered, overflow, last};
        idle_cycles <= 0;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
          end
        end
      end else if (!(in_valid && in_ready)) begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Watchdog: a long run with no item accepted and no result taken ends the test.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_item(op_t op, logic [31:0] s, logic [31:0] l);
    pending_items.push_back('{op, s, l});
  endtask

  // Random items: mostly adds near a small window so merges happen, or anywhere; some clear, list and gaps.
  task automatic add_random(int n);
    logic [31:0] s, l;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: add_item(OP_CLEAR, $urandom, $urandom);
        1, 2: add_item(OP_LIST, $urandom, $urandom);
        3, 4: add_item(OP_GAPS, $urandom, $urandom);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            s = $urandom; l = $urandom;
          end else begin
            s = $urandom_range(0, 2000); l = $urandom_range(0, 60);
          end
          add_item(OP_ADD, s, l);
        end
      endcase
    end
  endtask

  // Wait until every item is accepted and every result drained, then settle.
  task automatic drain();
    do @(posedge clk); while (!driver_done || in_valid || pending_items.size() != 0
                              || expected_results.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_file_size(logic [32:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    file_size = v;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty walks, extremes, zero length, touching and overlapping merges.
    write_file_size(33'h1_FFFF_FFFF);
    add_item(OP_LIST, '0, '0);
    add_item(OP_GAPS, '0, '0);
    add_item(OP_ADD, 32'd100, 32'd0);
    add_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_ADD, 32'd0, 32'd10);
    add_item(OP_ADD, 32'd10, 32'd5);
    add_item(OP_ADD, 32'd30, 32'd5);
    add_item(OP_ADD, 32'd12, 32'd20);
    add_item(OP_LIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_GAPS, '0, '0);
    add_item(OP_CLEAR, '0, '0);
    // Fill the table with separated ranges, then overflow it.
    for (int i = 0; i < 17; i++) add_item(OP_ADD, i * 10, 3);
    add_item(OP_LIST, '0, '0);
    drain();

    // Gap bound zero, then one inside the stored ranges; receiver stalls hard.
    write_file_size(33'd0);
    hold_off_req = 1'b1;
    add_item(OP_GAPS, '0, '0);
    add_item(OP_LIST, '0, '0);
    add_item(OP_GAPS, '0, '0);
    add_random(20);
    wait (hold_off_left > 0);
    hold_off_req = 1'b0;
    drain();

    write_file_size(33'd55);
    add_random(140);
    drain();
    write_file_size(33'd2100);
    add_random(140);
    drain();
    write_file_size({1'b0, $urandom});
    add_random(130);
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
